@@ src/telemetry_poll_responder_macros.svh @@
// Assertion macros for the telemetry poll responder.
// Used by tpr_datapath in src; needs clk_i and rst_ni in the including module.
`ifndef TELEMETRY_POLL_RESPONDER_MACROS_SVH
`define TELEMETRY_POLL_RESPONDER_MACROS_SVH
`ifndef SYNTHESIS
`define TPR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("telemetry_poll_responder assertion failed");
`define TPR_ASSERT_IMPLY(label, ante, cons) \
  `TPR_ASSERT(label, (ante) |-> (cons))
`else
`define TPR_ASSERT(label, prop)
`define TPR_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

@@ src/tpr_pkg.sv @@
// Shared constants, codes and controller/datapath structs of the poll responder.
// No dependencies.
package tpr_pkg;

  localparam int NUM_SLOTS = 8;
  localparam logic [3:0] SLOTS_MAX = 4'(NUM_SLOTS);

  localparam logic [7:0] FRAME_START   = 8'h7E;
  localparam logic [7:0] ESC_MARK      = 8'h7D;
  localparam logic [7:0] ESC_XOR       = 8'h20;
  localparam logic [7:0] SENSOR_HEADER = 8'h10;
  localparam logic [3:0] RX_LEN        = 4'd10;

  typedef enum logic [1:0] {
    CMD_RX_BYTE   = 2'd0,
    CMD_LOAD_SLOT = 2'd1,
    CMD_QUEUE     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_OWN_ID       = 2'd0,
    REG_COMMAND_ID   = 2'd1,
    REG_SENSOR_COUNT = 2'd2
  } reg_e;

  typedef struct packed {
    logic accept;
    logic search_step;
    logic send_step;
    logic rx_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_pending;
    logic go_search;
    logic rx_done;
    logic search_hit;
    logic search_miss;
    logic send_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/tpr_ctrl.sv @@
// Sequencer of the poll responder: accept, slot search, reply and report.
// Depends on tpr_pkg.
module tpr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tpr_pkg::dp_status_t status_i,
  output tpr_pkg::ctrl_cmd_t  cmd_o
);
  import tpr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SEND,
    ST_RXOUT
  } state_e;

  state_e state_q, state_d;
  logic   in_stall_q;
  logic   take;

  // Take a request only on a real handshake; stall is high in the first cycle after reset.
  assign take = in_valid_i && !in_stall_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = take;
        if (take) begin
          if (status_i.go_pending) state_d = ST_SEND;
          else if (status_i.go_search) state_d = ST_SEARCH;
          else if (status_i.rx_done) state_d = ST_RXOUT;
        end
      end
      ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (status_i.search_hit) state_d = ST_SEND;
        else if (status_i.search_miss) state_d = ST_IDLE;
      end
      ST_SEND: begin
        cmd_o.send_step = status_i.out_free;
        if (status_i.out_free && status_i.send_last) state_d = ST_IDLE;
      end
      ST_RXOUT: begin
        cmd_o.rx_emit = status_i.out_free;
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Accept only when idle; stall is registered from the next state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_stall_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_stall_q <= (state_d != ST_IDLE);
    end
  end

  assign in_stall_o = in_stall_q | (state_q != ST_IDLE);

endmodule

@@ src/tpr_datapath.sv @@
// Datapath of the poll responder: slot table, pending command, receive
// tracker, reply framer with checksum and escaping, output register. Uses tpr_pkg.
`include "telemetry_poll_responder_macros.svh"
module tpr_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpr_pkg::ctrl_cmd_t  cmd_i,
  output tpr_pkg::dp_status_t status_o,
  input  logic [4:0]          own_id_i,
  input  logic [4:0]          command_id_i,
  input  logic [3:0]          sensor_count_i,
  input  logic [1:0]          command_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                line_idle_i,
  input  logic [2:0]          slot_i,
  input  logic                slot_enable_i,
  input  logic [15:0]         app_id_i,
  input  logic [31:0]         data_value_i,
  input  logic [7:0]          cmd_prim_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                kind_o,
  output logic [7:0]          tx_byte_o,
  output logic                last_o,
  output logic                sensor_sent_o,
  output logic [2:0]          sent_slot_o,
  output logic [7:0]          rx_prim_o,
  output logic [15:0]         rx_app_id_o,
  output logic [31:0]         rx_value_o
);
  import tpr_pkg::*;

  logic        rx_active_q;
  logic [3:0]  rx_count_q;
  logic [7:0]  rx_store_q [7];
  logic [2:0]  next_slot_q;
  logic        slot_en_q   [NUM_SLOTS];
  logic [15:0] slot_app_q  [NUM_SLOTS];
  logic [31:0] slot_data_q [NUM_SLOTS];
  logic [7:0]  pend_prim_q;
  logic [15:0] pend_app_q;
  logic [31:0] pend_data_q;
  logic [2:0]  sidx_q, sstart_q;
  logic [7:0]  fr_prim_q;
  logic [15:0] fr_app_q;
  logic [31:0] fr_data_q;
  logic        fr_sensor_q;
  logic [2:0]  fr_slot_q;
  logic [2:0]  bi_q;
  logic        esc_q;
  logic        out_valid_q, out_kind_q, out_last_q, out_ss_q;
  logic [7:0]  out_tx_q, out_prim_q;
  logic [2:0]  out_slot_q;
  logic [15:0] out_app_q;
  logic [31:0] out_value_q;

  logic [3:0]  cnt_eff;
  logic        is_rx, is7e, idbyte, own_hit, reply, drop, act1;
  logic [3:0]  cnt1, cnt_off;
  logic        store_en;
  logic [2:0]  sstart, sinc;
  logic [3:0]  sidx_inc;
  logic        hit;
  logic [10:0] sum;
  logic [7:0]  folded, chk, fb, tx_now;
  logic        special, advance;

  assign cnt_eff = (sensor_count_i > SLOTS_MAX) ? SLOTS_MAX : sensor_count_i;

  // Receive tracking for a received byte.
  assign is_rx   = (command_i == CMD_RX_BYTE);
  assign is7e    = (rx_byte_i == FRAME_START);
  assign idbyte  = rx_active_q && (rx_count_q == 4'd1) && !is7e;
  assign own_hit = (rx_byte_i[4:0] == own_id_i) && line_idle_i;
  assign reply   = idbyte && own_hit;
  assign drop    = idbyte && !own_hit && (rx_byte_i[4:0] != command_id_i);
  assign act1    = is7e | (rx_active_q & ~drop);
  assign cnt1    = is7e ? 4'd0 : rx_count_q;
  assign cnt_off = cnt1 - 4'd2;
  assign store_en = (cnt1 >= 4'd2) && (cnt1 <= 4'd8);

  assign sstart   = ({1'b0, next_slot_q} >= cnt_eff) ? 3'd0 : next_slot_q;
  assign sidx_inc = {1'b0, sidx_q} + 4'd1;
  assign sinc     = (sidx_inc >= cnt_eff) ? 3'd0 : sidx_inc[2:0];
  assign hit      = slot_en_q[sidx_q] && (slot_app_q[sidx_q] != 16'd0);

  // Checksum: byte sum, add carries, invert.
  assign sum = 11'(fr_prim_q) + 11'(fr_app_q[7:0]) + 11'(fr_app_q[15:8])
             + 11'(fr_data_q[7:0]) + 11'(fr_data_q[15:8])
             + 11'(fr_data_q[23:16]) + 11'(fr_data_q[31:24]);
  assign folded = sum[7:0] + 8'(sum[10:8]);
  assign chk    = ~folded;

  always_comb begin
    case (bi_q)
      3'd0:    fb = fr_prim_q;
      3'd1:    fb = fr_app_q[7:0];
      3'd2:    fb = fr_app_q[15:8];
      3'd3:    fb = fr_data_q[7:0];
      3'd4:    fb = fr_data_q[15:8];
      3'd5:    fb = fr_data_q[23:16];
      3'd6:    fb = fr_data_q[31:24];
      default: fb = chk;
    endcase
  end

  assign special = (fb == FRAME_START) || (fb == ESC_MARK);
  assign advance = esc_q || !special;
  assign tx_now  = esc_q ? (fb ^ ESC_XOR) : (special ? ESC_MARK : fb);

  always_comb begin
    status_o.go_pending  = is_rx && reply && (pend_prim_q != 8'd0);
    status_o.go_search   = is_rx && reply && (pend_prim_q == 8'd0) && (cnt_eff != 4'd0);
    status_o.rx_done     = is_rx && !status_o.go_search && act1 && (cnt1 == RX_LEN - 4'd1);
    status_o.search_hit  = hit;
    status_o.search_miss = !hit && (sinc == sstart_q);
    status_o.send_last   = (bi_q == 3'd7) && advance;
    status_o.out_free    = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_active_q <= 1'b0;
      rx_count_q  <= 4'd0;
      next_slot_q <= 3'd0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_en_q[i]   <= 1'b0;
        slot_app_q[i]  <= 16'd0;
        slot_data_q[i] <= 32'd0;
      end
      pend_prim_q <= 8'd0;
      pend_app_q  <= 16'd0;
      pend_data_q <= 32'd0;
      bi_q        <= 3'd0;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        case (command_i)
          CMD_LOAD_SLOT: begin
            if (32'(slot_i) < NUM_SLOTS) begin
              slot_en_q[slot_i]   <= slot_enable_i;
              slot_app_q[slot_i]  <= app_id_i;
              slot_data_q[slot_i] <= data_value_i;
            end
          end
          CMD_QUEUE: begin
            pend_prim_q <= cmd_prim_i;
            pend_app_q  <= app_id_i;
            pend_data_q <= data_value_i;
          end
          CMD_RX_BYTE: begin
            if (status_o.go_pending) pend_prim_q <= 8'd0;
            if (status_o.go_search) begin
              next_slot_q <= sstart;
            end else if (act1) begin
              if (status_o.rx_done) begin
                rx_active_q <= 1'b0;
                rx_count_q  <= 4'd0;
              end else begin
                rx_active_q <= 1'b1;
                rx_count_q  <= cnt1 + 4'd1;
              end
            end else begin
              rx_active_q <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.search_step) begin
        if (hit) begin
          next_slot_q <= sinc;
          rx_active_q <= 1'b0;
        end else if (status_o.search_miss) begin
          rx_count_q  <= 4'd2;
        end
      end
      if (cmd_i.send_step) begin
        if (advance) begin
          esc_q <= 1'b0;
          bi_q  <= bi_q + 3'd1;
        end else begin
          esc_q <= 1'b1;
        end
      end
      if (cmd_i.send_step || cmd_i.rx_emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_rx && !status_o.go_search && act1 && store_en) begin
      rx_store_q[cnt_off[2:0]] <= rx_byte_i;
    end
    if (cmd_i.accept && status_o.go_pending) begin
      fr_prim_q   <= pend_prim_q;
      fr_app_q    <= pend_app_q;
      fr_data_q   <= pend_data_q;
      fr_sensor_q <= 1'b0;
      fr_slot_q   <= 3'd0;
    end
    if (cmd_i.accept && status_o.go_search) begin
      sidx_q   <= sstart;
      sstart_q <= sstart;
    end
    if (cmd_i.search_step) begin
      if (hit) begin
        fr_prim_q   <= SENSOR_HEADER;
        fr_app_q    <= slot_app_q[sidx_q];
        fr_data_q   <= slot_data_q[sidx_q];
        fr_sensor_q <= 1'b1;
        fr_slot_q   <= sidx_q;
      end else begin
        sidx_q <= sinc;
      end
    end
    if (cmd_i.send_step) begin
      out_kind_q  <= 1'b0;
      out_tx_q    <= tx_now;
      out_last_q  <= status_o.send_last;
      out_ss_q    <= status_o.send_last && fr_sensor_q;
      out_slot_q  <= fr_sensor_q ? fr_slot_q : 3'd0;
      out_prim_q  <= 8'd0;
      out_app_q   <= 16'd0;
      out_value_q <= 32'd0;
    end else if (cmd_i.rx_emit) begin
      out_kind_q  <= 1'b1;
      out_tx_q    <= 8'd0;
      out_last_q  <= 1'b0;
      out_ss_q    <= 1'b0;
      out_slot_q  <= 3'd0;
      out_prim_q  <= rx_store_q[0];
      out_app_q   <= {rx_store_q[2], rx_store_q[1]};
      out_value_q <= {rx_store_q[6], rx_store_q[5], rx_store_q[4], rx_store_q[3]};
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign tx_byte_o     = out_tx_q;
  assign last_o        = out_last_q;
  assign sensor_sent_o = out_ss_q;
  assign sent_slot_o   = out_slot_q;
  assign rx_prim_o     = out_prim_q;
  assign rx_app_id_o   = out_app_q;
  assign rx_value_o    = out_value_q;

  `TPR_ASSERT_IMPLY(a_report_no_tx, out_valid_q && out_kind_q, !out_last_q && !out_ss_q)
  `TPR_ASSERT_IMPLY(a_esc_on_special, esc_q, (fb == FRAME_START) || (fb == ESC_MARK))
  `TPR_ASSERT_IMPLY(a_rx_count_bound, rx_active_q, rx_count_q < RX_LEN)

endmodule

@@ src/telemetry_poll_responder.sv @@
// Top level of the telemetry poll responder: APB registers, sequencer, datapath.
// Depends on tpr_pkg, tpr_ctrl and tpr_datapath.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid_i/in_stall_o  command, rx_byte, line_idle, slot, ...
//   out      source     out_valid_o/out_stall_i kind, tx_byte, last, sent_slot, rx_*
//   cfg      APB slave  psel/penable/pready    own_id, command_id, sensor_count
//
// Slot loads, command queueing and plain received bytes leave the sequencer idle.
// A poll reply sends the queued command, if any, else searches up to NUM_SLOTS
// slots (one a cycle), then sends 8 to 16 bytes, one a cycle unless out stalls.
// A received command frame's report is loaded into the output register in ST_RXOUT.
// Reset clears all control, slot and pending state at once; no clearing pass.
// A stalled output holds its request and the sequence waits; input stalls while busy.
module telemetry_poll_responder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        line_idle_i,
  input  logic [2:0]  slot_i,
  input  logic        slot_enable_i,
  input  logic [15:0] app_id_i,
  input  logic [31:0] data_value_i,
  input  logic [7:0]  cmd_prim_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic        sensor_sent_o,
  output logic [2:0]  sent_slot_o,
  output logic [7:0]  rx_prim_o,
  output logic [15:0] rx_app_id_o,
  output logic [31:0] rx_value_o
);
  import tpr_pkg::*;

  logic [4:0] own_id_q, command_id_q;
  logic [3:0] sensor_count_q;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;

  // Write on the access phase; decode the word address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q       <= 5'd0;
      command_id_q   <= 5'd0;
      sensor_count_q <= 4'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_OWN_ID:       own_id_q       <= pwdata[4:0];
        REG_COMMAND_ID:   command_id_q   <= pwdata[4:0];
        REG_SENSOR_COUNT: sensor_count_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_OWN_ID:       prdata = 32'(own_id_q);
      REG_COMMAND_ID:   prdata = 32'(command_id_q);
      REG_SENSOR_COUNT: prdata = 32'(sensor_count_q);
      default:          prdata = 32'd0;
    endcase
  end

  tpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tpr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .own_id_i       (own_id_q),
    .command_id_i   (command_id_q),
    .sensor_count_i (sensor_count_q),
    .command_i      (command_i),
    .rx_byte_i      (rx_byte_i),
    .line_idle_i    (line_idle_i),
    .slot_i         (slot_i),
    .slot_enable_i  (slot_enable_i),
    .app_id_i       (app_id_i),
    .data_value_i   (data_value_i),
    .cmd_prim_i     (cmd_prim_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .tx_byte_o      (tx_byte_o),
    .last_o         (last_o),
    .sensor_sent_o  (sensor_sent_o),
    .sent_slot_o    (sent_slot_o),
    .rx_prim_o      (rx_prim_o),
    .rx_app_id_o    (rx_app_id_o),
    .rx_value_o     (rx_value_o)
  );

endmodule
